### rtl/adpc_pkg.sv
package adpc_pkg;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      REQ_SAMPLE    = 2'd0,
      REQ_BUTTON    = 2'd1,
      REQ_SET_MAN   = 2'd2,
      REQ_CALIBRATE = 2'd3
   } req_kind_type;

   // Door states as reported on the result channel.
   typedef enum logic [1:0] {
      DOOR_CLOSED = 2'd0,
      DOOR_OPEN   = 2'd1,
      DOOR_WAIT   = 2'd2
   } door_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CLOSED_ANGLE   = 3'd0;
   localparam logic [2:0] CSR_ROTATION_ANGLE = 3'd1;
   localparam logic [2:0] CSR_DETECT_THRESH  = 3'd2;
   localparam logic [2:0] CSR_DEBOUNCE       = 3'd3;
   localparam logic [2:0] CSR_PRES_TIMEOUT   = 3'd4;
   localparam logic [2:0] CSR_CLOSE_DELAY    = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0] ANGLE_MAX = 8'd180;

   typedef struct packed {
      logic        [7:0]  closed_angle;
      logic signed [8:0]  rotation_angle;
      logic        [11:0] detect_threshold;
      logic        [15:0] debounce_ms;
      logic        [15:0] presence_timeout_ms;
      logic        [15:0] close_delay_ms;
   } cfg_type;

   // Fixed-width part of one result item.
   typedef struct packed {
      door_type   door_state;
      logic [7:0] servo_target;
      logic       servo_update;
      logic       detect_flag;
      logic       present_flag;
      logic       manual_mode;
   } status_type;

endpackage

### rtl/adpc_csr.sv
module adpc_csr
   import adpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed_angle        <= 8'd0;
         cfg_ff.rotation_angle      <= 9'sd90;
         cfg_ff.detect_threshold    <= 12'd160;
         cfg_ff.debounce_ms         <= 16'd200;
         cfg_ff.presence_timeout_ms <= 16'd3000;
         cfg_ff.close_delay_ms      <= 16'd2000;
      end else if (wr_en) begin
         case (wr_index)
            CSR_CLOSED_ANGLE:   cfg_ff.closed_angle        <= wr_data[7:0];
            CSR_ROTATION_ANGLE: cfg_ff.rotation_angle      <= $signed(wr_data[8:0]);
            CSR_DETECT_THRESH:  cfg_ff.detect_threshold    <= wr_data[11:0];
            CSR_DEBOUNCE:       cfg_ff.debounce_ms         <= wr_data;
            CSR_PRES_TIMEOUT:   cfg_ff.presence_timeout_ms <= wr_data;
            CSR_CLOSE_DELAY:    cfg_ff.close_delay_ms      <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/adpc_step.sv
module adpc_step
   import adpc_pkg::*;
#(
   parameter int TIME_WIDTH = 32,
   parameter int DIST_WIDTH = 16
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  cfg_type                      cfg,
   input  req_kind_type                 req_type,
   input  logic [TIME_WIDTH-1:0]        now_ms,
   input  logic [DIST_WIDTH-1:0]        distance,
   input  logic                         distance_valid,
   input  logic                         manual_value,
   input  logic [DIST_WIDTH-1:0]        new_baseline,
   output status_type                   status,
   output logic signed [DIST_WIDTH:0]   distance_diff
);

   // Width wide enough for both the signed difference and the 12-bit threshold.
   localparam int CMP_W = (DIST_WIDTH + 2 > 14) ? DIST_WIDTH + 2 : 14;

   door_type                  door_ff, door_in;
   logic [DIST_WIDTH-1:0]     base_ff, base_in;
   logic                      detecting_ff, detecting_in;
   logic [TIME_WIDTH-1:0]     det_start_ff, det_start_in;
   logic [TIME_WIDTH-1:0]     last_seen_ff, last_seen_in;
   logic [TIME_WIDTH-1:0]     close_start_ff, close_start_in;
   logic                      manual_ff, manual_in;
   logic                      held_det_ff, held_det_in;
   logic                      held_pres_ff, held_pres_in;
   logic signed [DIST_WIDTH:0] held_diff_ff, held_diff_in;
   logic [7:0]                held_servo_ff, held_servo_in;
   logic                      update;

   logic signed [DIST_WIDTH:0] diff;
   logic signed [CMP_W-1:0]    diff_x, thr_x;
   logic                      det;
   logic [TIME_WIDTH-1:0]     start_eff, since_det, since_seen, since_close;
   logic                      pres;
   logic signed [9:0]         open_sum;
   logic [7:0]                open_angle, closed_servo;

   assign diff   = $signed({1'b0, base_ff}) - $signed({1'b0, distance});
   assign diff_x = CMP_W'(diff);
   assign thr_x  = $signed({{(CMP_W-12){1'b0}}, cfg.detect_threshold});
   assign det    = diff_x >= thr_x;

   assign open_sum = $signed({2'b00, cfg.closed_angle}) + 10'(cfg.rotation_angle);

   always_comb begin
      if (open_sum < 10'sd0)
         open_angle = 8'd0;
      else if (open_sum > $signed({2'b00, ANGLE_MAX}))
         open_angle = ANGLE_MAX;
      else
         open_angle = open_sum[7:0];
   end

   assign closed_servo = (cfg.closed_angle > ANGLE_MAX) ? ANGLE_MAX : cfg.closed_angle;

   // A fresh detection starts its debounce window at this item's time.
   assign start_eff   = detecting_ff ? det_start_ff : now_ms;
   assign since_det   = now_ms - start_eff;
   assign since_close = now_ms - close_start_ff;

   always_comb begin
      door_in        = door_ff;
      base_in        = base_ff;
      detecting_in   = detecting_ff;
      det_start_in   = det_start_ff;
      last_seen_in   = last_seen_ff;
      close_start_in = close_start_ff;
      manual_in      = manual_ff;
      held_det_in    = held_det_ff;
      held_pres_in   = held_pres_ff;
      held_diff_in   = held_diff_ff;
      held_servo_in  = held_servo_ff;
      update         = 1'b0;
      since_seen     = now_ms - last_seen_ff;
      pres           = 1'b0;

      case (req_type)
         REQ_SAMPLE: begin
            if (!manual_ff && distance_valid) begin
               held_diff_in = diff;
               held_det_in  = det;
               if (det) begin
                  detecting_in = 1'b1;
                  det_start_in = start_eff;
                  if (since_det >= TIME_WIDTH'(cfg.debounce_ms))
                     last_seen_in = now_ms;
               end else begin
                  detecting_in = 1'b0;
               end
               since_seen   = now_ms - last_seen_in;
               pres         = since_seen < TIME_WIDTH'(cfg.presence_timeout_ms);
               held_pres_in = pres;
               case (door_ff)
                  DOOR_CLOSED: begin
                     if (pres) begin
                        held_servo_in = open_angle;
                        update        = 1'b1;
                        door_in       = DOOR_OPEN;
                     end
                  end
                  DOOR_OPEN: begin
                     if (!pres) begin
                        door_in        = DOOR_WAIT;
                        close_start_in = now_ms;
                     end
                  end
                  default: begin
                     if (pres) begin
                        door_in = DOOR_OPEN;
                     end else if (since_close >= TIME_WIDTH'(cfg.close_delay_ms)) begin
                        held_servo_in = closed_servo;
                        update        = 1'b1;
                        door_in       = DOOR_CLOSED;
                     end
                  end
               endcase
            end
         end
         REQ_BUTTON: begin
            manual_in = 1'b1;
            if (door_ff == DOOR_CLOSED) begin
               held_servo_in = open_angle;
               door_in       = DOOR_OPEN;
            end else begin
               held_servo_in = closed_servo;
               door_in       = DOOR_CLOSED;
            end
            update       = 1'b1;
            detecting_in = 1'b0;
            held_det_in  = 1'b0;
            held_pres_in = 1'b0;
         end
         REQ_SET_MAN: begin
            manual_in = manual_value;
         end
         default: begin
            base_in      = new_baseline;
            door_in      = DOOR_CLOSED;
            detecting_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         door_ff        <= DOOR_CLOSED;
         base_ff        <= '0;
         detecting_ff   <= 1'b0;
         det_start_ff   <= '0;
         last_seen_ff   <= '0;
         close_start_ff <= '0;
         manual_ff      <= 1'b0;
         held_det_ff    <= 1'b0;
         held_pres_ff   <= 1'b0;
         held_diff_ff   <= '0;
         held_servo_ff  <= 8'd0;
      end else if (fire) begin
         door_ff        <= door_in;
         base_ff        <= base_in;
         detecting_ff   <= detecting_in;
         det_start_ff   <= det_start_in;
         last_seen_ff   <= last_seen_in;
         close_start_ff <= close_start_in;
         manual_ff      <= manual_in;
         held_det_ff    <= held_det_in;
         held_pres_ff   <= held_pres_in;
         held_diff_ff   <= held_diff_in;
         held_servo_ff  <= held_servo_in;
      end
   end

   assign status.door_state   = door_in;
   assign status.servo_target = held_servo_in;
   assign status.servo_update = update;
   assign status.detect_flag  = held_det_in;
   assign status.present_flag = held_pres_in;
   assign status.manual_mode  = manual_in;
   assign distance_diff       = held_diff_in;

endmodule

### rtl/auto_door_presence_controller.sv
// Flow: an accepted item is held in the input register, processed by the step logic into
// the result register when that register is free, and offered on the rsp channel from there.
// Throughput: one item per cycle while rsp_tready is high; the input register and the
// result register let a new item enter while a finished result still waits to be taken.
// Reset (synchronous, active high) closes the door, clears all history and loads the
// configuration registers with their default values.
module auto_door_presence_controller
   import adpc_pkg::*;
#(
   parameter int TIME_WIDTH = 32,
   parameter int DIST_WIDTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,

   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0 up: now_ms, distance, distance_valid, manual_value,
   // new_baseline, then zero padding to a whole byte.
   input  logic [((TIME_WIDTH + 2*DIST_WIDTH + 2 + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0 up: req_type.
   input  logic [1:0]             req_tuser,

   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0 up: door_state, servo_target, servo_update, detect_flag,
   // present_flag, distance_diff, manual_mode, then zero padding.
   output logic [((DIST_WIDTH + 15 + 7) / 8) * 8 - 1:0] rsp_tdata,

   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int REQ_BITS = TIME_WIDTH + 2*DIST_WIDTH + 2;
   localparam int RSP_BITS = DIST_WIDTH + 15;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Bit positions inside req_tdata.
   localparam int DIST_LO  = TIME_WIDTH;
   localparam int VALID_B  = TIME_WIDTH + DIST_WIDTH;
   localparam int MVAL_B   = VALID_B + 1;
   localparam int BASE_LO  = MVAL_B + 1;

   cfg_type                    cfg;
   status_type                 status;
   logic signed [DIST_WIDTH:0] diff;

   // The input register holds one accepted item until the step logic consumes it.
   logic                       in_valid_ff, in_valid_in;
   logic [REQ_BITS-1:0]        in_data_ff;
   logic [1:0]                 in_kind_ff;

   // The result register holds one finished item for the rsp side.
   logic                       out_valid_ff, out_valid_in;
   logic [RSP_BITS-1:0]        out_data_ff;

   logic                       out_free;
   logic                       step_fire;
   logic                       req_fire;

   // The result register can take a new item when it is empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration is taken at any time; the user must write it only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;

   adpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   adpc_step #(
      .TIME_WIDTH (TIME_WIDTH),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (step_fire),
      .cfg            (cfg),
      .req_type       (req_kind_type'(in_kind_ff)),
      .now_ms         (in_data_ff[TIME_WIDTH-1:0]),
      .distance       (in_data_ff[VALID_B-1:DIST_LO]),
      .distance_valid (in_data_ff[VALID_B]),
      .manual_value   (in_data_ff[MVAL_B]),
      .new_baseline   (in_data_ff[REQ_BITS-1:BASE_LO]),
      .status         (status),
      .distance_diff  (diff)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (step_fire)
         in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (step_fire)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on a transfer and need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata[REQ_BITS-1:0];
         in_kind_ff <= req_tuser;
      end
      if (step_fire) begin
         out_data_ff <= {status.manual_mode, diff, status.present_flag,
                         status.detect_flag, status.servo_update,
                         status.servo_target, status.door_state};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(out_data_ff);

endmodule

### rtl/adpc_checker.sv
module adpc_checker
   import adpc_pkg::*;
#(
   parameter int DIST_WIDTH = 16
)(
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_tvalid,
   input logic                                     rsp_tready,
   input logic [((DIST_WIDTH + 15 + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int MAN_B = DIST_WIDTH + 14;

   logic [1:0] door_state;
   logic [7:0] servo_target;
   logic       servo_update;
   logic       detect_flag;
   logic       present_flag;
   logic       manual_mode;

   assign door_state   = rsp_tdata[1:0];
   assign servo_target = rsp_tdata[9:2];
   assign servo_update = rsp_tdata[10];
   assign detect_flag  = rsp_tdata[11];
   assign present_flag = rsp_tdata[12];
   assign manual_mode  = rsp_tdata[MAN_B];

   // No result may be offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result stays and keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A servo command always leaves the door fully open or fully closed.
   a_update_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && servo_update |->
         door_state == DOOR_CLOSED || door_state == DOOR_OPEN)
      else $error("servo command while waiting to close");

   // In manual mode only the button moves the servo, and it clears the decisions.
   a_manual_update: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && servo_update && manual_mode |-> !detect_flag && !present_flag)
      else $error("manual servo command with live detection");

   // The commanded angle never leaves the servo range.
   a_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> servo_target <= ANGLE_MAX)
      else $error("servo angle out of range");

endmodule

bind auto_door_presence_controller adpc_checker #(
   .DIST_WIDTH (DIST_WIDTH)
) u_adpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
